// ===== rtl/fqd_pkg.sv =====
// Shared types and constants for the fractional quotient divider.
// Depends on nothing; every other file imports it.
package fqd_pkg;

   // Width of every numeric field on the ports.
   localparam int FQD_FIELD_BITS = 64;

   // Default arithmetic word width of the divider.
   localparam int FQD_WORD_BITS = 64;

   // Request beat: dividend and divisor.
   typedef struct packed {
      logic [FQD_FIELD_BITS-1:0] numer;
      logic [FQD_FIELD_BITS-1:0] denom;
   } fqd_req_type;

   // Response beat: binary fraction of the quotient and the zero-divisor flag.
   typedef struct packed {
      logic [FQD_FIELD_BITS-1:0] fraction;
      logic                      div_by_zero;
   } fqd_rsp_type;

endpackage

// ===== rtl/fractional_quotient_divider_top.sv =====
// Fractional quotient divider: fraction of numer / denom as a binary fraction.
// Depends on fqd_pkg and fqd_cell.
//
// Usage:
//   The request channel (req_valid, req_ready, req_data) carries an unsigned
//   numerator and denominator; only their low WORD_BITS bits count. The
//   response channel (rsp_valid, rsp_ready, rsp_data) returns
//   floor((numer mod denom) * 2^WORD_BITS / denom) and a div_by_zero flag.
//   A zero denominator returns a fraction of 0 with div_by_zero set.
//   From request beat to response valid, each beat passes through
//   a row of 2*WORD_BITS restoring cells, the first WORD_BITS forming the
//   remainder and the rest the fraction bits, then the response register.
//   Throughput is one beat per cycle while the row advances; every cell holds its own item.
//   When the receiver stalls with a response waiting, the whole row holds and
//   req_ready drops; an empty response register lets the row keep moving.
//   Reset clears all valid bits, the response valid among them; no beats are in
//   flight afterward and req_ready is high.
module fractional_quotient_divider_top
   import fqd_pkg::*;
#(
   parameter int WORD_BITS = FQD_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  fqd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output fqd_rsp_type rsp_data
);

   localparam int STAGES = 2 * WORD_BITS;

   logic                 advance;
   logic                 valid_s [0:STAGES];
   logic [WORD_BITS-1:0] rem_s   [0:STAGES];
   logic [WORD_BITS-1:0] denom_s [0:STAGES];
   logic [WORD_BITS-1:0] word_s  [0:STAGES];

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   fqd_rsp_type          rsp_data_ff;
   fqd_rsp_type          rsp_data_in;
   logic                 zero_div;

   // The row moves whenever the response register is empty or being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Row entry: remainder starts empty, the word holds the numerator bits.
   assign valid_s[0] = req_valid;
   assign rem_s[0]   = '0;
   assign denom_s[0] = req_data.denom[WORD_BITS-1:0];
   assign word_s[0]  = req_data.numer[WORD_BITS-1:0];

   // Cells 0..WORD_BITS-1 reduce the numerator to its remainder; past that
   // point the word restarts empty so only zeros shift in and fraction bits collect.
   for (genvar k = 0; k < STAGES; k++) begin : g_cell
      logic [WORD_BITS-1:0] cell_word;

      if (k == WORD_BITS) begin : g_restart
         assign cell_word = '0;
      end else begin : g_pass
         assign cell_word = word_s[k];
      end

      fqd_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_s[k]),
         .in_rem    (rem_s[k]),
         .in_denom  (denom_s[k]),
         .in_word   (cell_word),
         .out_valid (valid_s[k+1]),
         .out_rem   (rem_s[k+1]),
         .out_denom (denom_s[k+1]),
         .out_word  (word_s[k+1])
      );
   end

   // Response formatting: a zero divisor forces the fraction to zero.
   always_comb begin
      zero_div                = (denom_s[STAGES] == '0);
      rsp_valid_in            = valid_s[STAGES];
      rsp_data_in.div_by_zero = zero_div;
      rsp_data_in.fraction    = zero_div ? '0
                              : FQD_FIELD_BITS'(word_s[STAGES]);
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/fqd_cell.sv =====
// One restoring division step with its pipeline register.
// Depends on fqd_pkg; instantiated in a row by fractional_quotient_divider_top.
module fqd_cell
   import fqd_pkg::*;
#(
   parameter int WORD_BITS = FQD_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [WORD_BITS-1:0] in_rem,
   input  logic [WORD_BITS-1:0] in_denom,
   input  logic [WORD_BITS-1:0] in_word,
   output logic                 out_valid,
   output logic [WORD_BITS-1:0] out_rem,
   output logic [WORD_BITS-1:0] out_denom,
   output logic [WORD_BITS-1:0] out_word
);

   logic                 valid_ff;
   logic [WORD_BITS-1:0] rem_ff;
   logic [WORD_BITS-1:0] denom_ff;
   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS:0]   rem_shift;
   logic [WORD_BITS:0]   rem_diff;
   logic                 take;
   logic [WORD_BITS-1:0] rem_in;
   logic [WORD_BITS-1:0] word_in;

   // Shift the top bit of the word into the partial remainder and try the divisor.
   always_comb begin
      rem_shift = {in_rem, in_word[WORD_BITS-1]};
      rem_diff  = rem_shift - {1'b0, in_denom};
      take      = (rem_shift >= {1'b0, in_denom});
      rem_in    = take ? rem_diff[WORD_BITS-1:0] : rem_shift[WORD_BITS-1:0];
      word_in   = {in_word[WORD_BITS-2:0], take};
   end

   // Valid bit is control and resets; the data only moves when the row advances.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff   <= rem_in;
         denom_ff <= in_denom;
         word_ff  <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_denom = denom_ff;
   assign out_word  = word_ff;

endmodule

// ===== rtl/fqd_checker.sv =====
// Port-level checks for the fractional quotient divider, bound to its top level.
// Depends on fqd_pkg and fractional_quotient_divider_top.
module fqd_checker
   import fqd_pkg::*;
#(
   parameter int WORD_BITS = FQD_WORD_BITS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input fqd_rsp_type rsp_data
);

   // A stalled response beat holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // The divider never holds off requests while its output side is free.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with an empty response register");

   // A zero divisor always reports a zero fraction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_by_zero |-> rsp_data.fraction == '0)
      else $error("nonzero fraction on a zero divisor");

   // The fraction never carries bits above the word width.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fraction >> WORD_BITS) == '0)
      else $error("fraction has bits above the word width");

   // Nothing is presented on the first cycle after reset is released.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind fractional_quotient_divider_top fqd_checker #(
   .WORD_BITS (WORD_BITS)
) u_fqd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/fractional_quotient_divider_top_test.sv =====
// Self-checking testbench for the fractional quotient divider top level.
// Depends on fqd_pkg and fractional_quotient_divider_top; predicts each
// response with 128-bit long division and checks it against the response beat.
`timescale 1ns / 100ps

module fractional_quotient_divider_top_test;
   import fqd_pkg::*;

   localparam int WORD_BITS = FQD_WORD_BITS;
   localparam int LATENCY = 2 * WORD_BITS + 1;
   localparam int IDLE_LIMIT = 4000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [FQD_FIELD_BITS-1:0] WORD_MASK =
      {FQD_FIELD_BITS{1'b1}} >> (FQD_FIELD_BITS - WORD_BITS);
   localparam logic [FQD_FIELD_BITS-1:0] MAX_WORD = {FQD_FIELD_BITS{1'b1}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   fqd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   fqd_rsp_type rsp_data;

   // Quotients still in flight, oldest first.
   fqd_rsp_type expected_fractions[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_left = 0;
   int failures = 0;
   int responses_checked = 0;
   int zero_divisors_checked = 0;
   int requests_sent = 0;
   int input_stall_cycles = 0;
   int quiet_cycles = 0;

   fractional_quotient_divider_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Free-running clock, 20 ns period.
   always #10 clock = ~clock;

   // Fraction of numer / denom: the remainder shifted up by the word width,
   // divided once more. A zero divisor gives a zero fraction and the flag.
   function automatic fqd_rsp_type predict_fraction(input fqd_req_type beat);
      logic [FQD_FIELD_BITS-1:0]   numer_w;
      logic [FQD_FIELD_BITS-1:0]   denom_w;
      logic [2*FQD_FIELD_BITS-1:0] scaled_rem;
      logic [2*FQD_FIELD_BITS-1:0] quotient;
      fqd_rsp_type                 result;
      numer_w = beat.numer & WORD_MASK;
      denom_w = beat.denom & WORD_MASK;
      result = '0;
      if (denom_w == '0) begin
         result.div_by_zero = 1'b1;
      end else begin
         scaled_rem = {{FQD_FIELD_BITS{1'b0}}, numer_w % denom_w} << WORD_BITS;
         quotient = scaled_rem / {{FQD_FIELD_BITS{1'b0}}, denom_w};
         result.fraction = quotient[FQD_FIELD_BITS-1:0] & WORD_MASK;
      end
      return result;
   endfunction

   function automatic fqd_req_type make_division(input logic [FQD_FIELD_BITS-1:0] numer,
                                                 input logic [FQD_FIELD_BITS-1:0] denom);
      fqd_req_type beat;
      beat.numer = numer;
      beat.denom = denom;
      return beat;
   endfunction

   function automatic logic [FQD_FIELD_BITS-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Mix of operand shapes: fully random pairs, zero divisors, small operands,
   // proper fractions, powers of two and values near the top of the range.
   function automatic fqd_req_type random_division();
      logic [FQD_FIELD_BITS-1:0] numer;
      logic [FQD_FIELD_BITS-1:0] denom;
      numer = random_word();
      denom = random_word();
      case ($urandom_range(0, 9))
         0: denom = '0;
         1: begin
            numer = FQD_FIELD_BITS'($urandom_range(0, 255));
            denom = FQD_FIELD_BITS'($urandom_range(1, 255));
         end
         2: begin
            if (denom == '0) denom = 64'd1;
            numer = numer % denom;
         end
         3: denom = 64'd1 << $urandom_range(0, FQD_FIELD_BITS - 1);
         4: denom = MAX_WORD - $urandom_range(0, 15);
         5: numer = denom - $urandom_range(0, 2);
         6: denom = denom >> $urandom_range(1, FQD_FIELD_BITS - 1);
         default: ;
      endcase
      return make_division(numer, denom);
   endfunction

   // Offer one request beat, possibly after an idle gap, and hold it until the
   // divider takes it. The prediction is queued at the accepting edge.
   task automatic send_division(input fqd_req_type beat);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      expected_fractions.push_back(predict_fraction(beat));
      requests_sent++;
   endtask

   // Drop valid and pause until every queued result has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_fractions.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_corners();
      send_division(make_division('0, '0));
      send_division(make_division(MAX_WORD, '0));
      send_division(make_division('0, 64'd1));
      send_division(make_division(MAX_WORD, 64'd1));
      send_division(make_division('0, MAX_WORD));
      send_division(make_division(64'd1, MAX_WORD));
      send_division(make_division(MAX_WORD, MAX_WORD));
      send_division(make_division(MAX_WORD - 64'd1, MAX_WORD));
      send_division(make_division(MAX_WORD, MAX_WORD - 64'd1));
      send_division(make_division(64'd1, 64'd2));
      send_division(make_division(64'd1, 64'd3));
      send_division(make_division(64'd2, 64'd3));
      send_division(make_division(64'd7, 64'd3));
      send_division(make_division(64'd22, 64'd7));
      send_division(make_division(64'd355, 64'd113));
      send_division(make_division(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001));
      send_division(make_division(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000));
      send_division(make_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
      send_division(make_division(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
      send_division(make_division(64'd1, 64'h8000_0000_0000_0000));
      send_division(make_division(64'd12345, 64'd12345));
      send_division(make_division(MAX_WORD, 64'd10));
      wait_for_drain();
   endtask

   task automatic test_random_divisions(input int count);
      repeat (count) send_division(random_division());
      wait_for_drain();
   endtask

   // The receiver holds off long enough for the whole row of cells to fill,
   // so req_ready has to drop while the sender keeps offering beats.
   task automatic test_output_backpressure(input int count);
      @(negedge clock);
      hold_off_left = 3 * LATENCY;
      repeat (count) send_division(random_division());
      wait_for_drain();
   endtask

   // Receiver side: random stalls, or a counted hold-off when one is pending.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Compare each response beat with the oldest prediction, field by field.
   always @(posedge clock) begin
      fqd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fractions.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: response with none outstanding: fraction=%h div_by_zero=%b",
                        rsp_data.fraction, rsp_data.div_by_zero);
         end else begin
            want = expected_fractions.pop_front();
            responses_checked++;
            if (want.div_by_zero) zero_divisors_checked++;
            if (rsp_data.fraction !== want.fraction
                || rsp_data.div_by_zero !== want.div_by_zero) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("ERROR: response %0d: fraction exp %h got %h, div_by_zero exp %b got %b",
                           responses_checked, want.fraction, rsp_data.fraction,
                           want.div_by_zero, rsp_data.div_by_zero);
            end
         end
      end
   end

   // Watchdog on cycles with no beat on either channel; also counts input stalls.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_ready) input_stall_cycles++;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
               $display("ERROR: no beat moved for %0d cycles, %0d results outstanding",
                        quiet_cycles, expected_fractions.size());
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();

      send_idle_pct = 8;
      recv_idle_pct = 65;
      test_random_divisions(250);

      send_idle_pct = 65;
      recv_idle_pct = 8;
      test_random_divisions(250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_output_backpressure(160);
      test_random_divisions(80);

      repeat (LATENCY + 20) @(posedge clock);
      if (expected_fractions.size() != 0) begin
         failures++;
         $display("ERROR: %0d results never arrived", expected_fractions.size());
      end

      $display("Checked %0d divisions (%0d by zero) from %0d requests.",
               responses_checked, zero_divisors_checked, requests_sent);
      $display("Input side was held off by response backpressure for %0d cycles.",
               input_stall_cycles);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures", failures);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
